// File: design/cbm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the cartridge bus mapper.
// No dependencies.
package cbm_pkg;

    typedef enum logic [1:0] {
        REGION_NONE = 2'd0,
        REGION_ROM  = 2'd1,
        REGION_SRAM = 2'd2
    } t_region;

    typedef struct packed {
        t_region     region;
        logic [22:0] rom_index;
        logic        slow;
        logic        sram_en;
    } t_decode;

    localparam logic [1:0] CFG_ROM_LAYOUT      = 2'd0;
    localparam logic [1:0] CFG_SRAM_SIZE_CODE  = 2'd1;
    localparam logic [1:0] CFG_FAST_ROM_ENABLE = 2'd2;

    localparam int LAYOUT_HI_BIT = 0;
    localparam int LAYOUT_EX_BIT = 1;

    localparam logic [7:0]  BANK_WRAM_LO     = 8'h7E;
    localparam logic [7:0]  BANK_WRAM_HI     = 8'h7F;
    localparam logic [7:0]  BANK_SRAM_LO     = 8'h70;
    localparam logic [7:0]  BANK_SRAM_LO_END = 8'h7D;
    localparam logic [7:0]  BANK_SRAM_HI     = 8'hF0;
    localparam logic [7:0]  BANK_FAST        = 8'h80;
    localparam logic [7:0]  BANK_EX_SPLIT    = 8'hC0;
    localparam logic [7:0]  BANK_HI_WHOLE    = 8'hFE;
    localparam logic [6:0]  HI_WHOLE_LO      = 7'h40;
    localparam logic [6:0]  HI_WHOLE_END     = 7'h7D;
    localparam logic [6:0]  HI_SRAM_LO       = 7'h20;
    localparam logic [6:0]  HI_SRAM_END      = 7'h3F;
    localparam logic [15:0] OFFSET_ROM       = 16'h8000;
    localparam logic [15:0] OFFSET_HI_SRAM   = 16'h6000;
    localparam logic [22:0] EX_ROM_BASE      = 23'h400000;
    localparam logic [25:0] SRAM_UNIT        = 26'h800;

endpackage

// File: design/cbm_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
module cbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/cbm_decode.sv
`timescale 1ns / 1ps
// Address decoder: region, ROM index, save RAM index and timing for one access.
// Depends on cbm_pkg.
module cbm_decode #(
    parameter int SAVE_RAM_BYTES  = 524288,
    parameter int ROM_SPACE_BYTES = 8388608,
    localparam int SW = $clog2(SAVE_RAM_BYTES)
) (
    input  logic [1:0]       i_rom_layout,
    input  logic [3:0]       i_sram_size_code,
    input  logic             i_fast_rom_enable,
    input  logic [23:0]      i_address,
    output cbm_pkg::t_decode o_dec,
    output logic [SW-1:0]    o_sram_index
);
    import cbm_pkg::*;

    localparam logic [22:0] ROM_MASK   = 23'(ROM_SPACE_BYTES - 1);
    localparam logic [25:0] SAVE_LIMIT = 26'(SAVE_RAM_BYTES);

    logic [7:0]  bank;
    logic [15:0] offset;
    logic [6:0]  low_bank;
    logic        hi;
    logic        ex;
    logic        wram;
    logic        has_sram;
    logic        whole;
    logic        rom_hit;
    logic        sram_hit;
    logic [25:0] size_full;
    logic [25:0] size;
    logic [25:0] size_mask;
    logic [25:0] sram_raw;
    logic [25:0] sram_masked;
    logic [21:0] rom_base;
    logic [22:0] rom_full;
    t_region     region;

    always_comb begin
        bank      = i_address[23:16];
        offset    = i_address[15:0];
        low_bank  = bank[6:0];
        hi        = i_rom_layout[LAYOUT_HI_BIT];
        ex        = i_rom_layout[LAYOUT_EX_BIT];
        wram      = (bank == BANK_WRAM_LO) || (bank == BANK_WRAM_HI);
        has_sram  = (i_sram_size_code != 4'd0);
        size_full = SRAM_UNIT << (i_sram_size_code - 4'd1);
        size      = (size_full > SAVE_LIMIT) ? SAVE_LIMIT : size_full;
        size_mask = size - 26'd1;
        whole     = ((low_bank >= HI_WHOLE_LO) && (low_bank <= HI_WHOLE_END))
                    || (bank >= BANK_HI_WHOLE);

        if (hi) begin
            rom_hit  = whole || (offset >= OFFSET_ROM);
            sram_hit = has_sram && (low_bank >= HI_SRAM_LO) && (low_bank <= HI_SRAM_END)
                       && (offset >= OFFSET_HI_SRAM);
            rom_base = i_address[21:0];
            sram_raw = {8'd0, i_address[20:16], i_address[12:0]};
        end else begin
            rom_hit  = (offset >= OFFSET_ROM);
            sram_hit = has_sram && (((bank >= BANK_SRAM_LO) && (bank <= BANK_SRAM_LO_END))
                       || (bank >= BANK_SRAM_HI));
            rom_base = {i_address[22:16], i_address[14:0]};
            sram_raw = {3'd0, i_address[23:16], i_address[14:0]};
        end

        if (wram) begin
            region = REGION_NONE;
        end else if (rom_hit) begin
            region = REGION_ROM;
        end else if (sram_hit) begin
            region = REGION_SRAM;
        end else begin
            region = REGION_NONE;
        end

        rom_full = {1'b0, rom_base};
        if (ex && (bank < BANK_EX_SPLIT)) begin
            rom_full = rom_full | EX_ROM_BASE;
        end

        sram_masked = sram_raw & size_mask;

        o_dec.region    = region;
        o_dec.rom_index = (region == REGION_ROM) ? (rom_full & ROM_MASK) : 23'd0;
        o_dec.slow      = (region != REGION_NONE)
                          && !((bank >= BANK_FAST) && i_fast_rom_enable);
        o_dec.sram_en   = (region == REGION_SRAM) && (sram_masked < SAVE_LIMIT);
        o_sram_index    = sram_masked[SW-1:0];
    end

endmodule

// File: design/cartridge_bus_mapper_top.sv
`timescale 1ns / 1ps
// Top level of the cartridge bus mapper: config registers, access pipeline, save RAM.
// Depends on cbm_pkg, cbm_decode and cbm_ram.
//
// Usage:
// The access channel (i_valid, o_stall, i_operation, i_address, i_write_data)
// carries one bus access per transfer. The result channel (o_valid, i_stall,
// o_region, o_rom_index, o_read_data, o_slow_access) returns one result per access,
// in order. Configuration is written through i_cfg_valid/o_cfg_ready with a
// register index and data; the port is always ready. The user must write it
// only while the block is idle; the block itself does not enforce this.
// An access is decoded in the cycle it is accepted and the save RAM is read or
// written in that cycle; the registered read data joins the result when the access
// moves from the decode stage register into the result register. One access is
// taken every cycle while o_stall is low; the single save RAM port pair sustains
// one access per cycle. After reset the save RAM is cleared one byte per cycle,
// all SAVE_RAM_BYTES bytes, while o_stall stays high. Config registers reset to zero.
// When the receiver stalls, the result register holds, one more access may
// sit in the decode stage, and then o_stall rises.
module cartridge_bus_mapper_top #(
    parameter int SAVE_RAM_BYTES  = 524288,
    parameter int ROM_SPACE_BYTES = 8388608
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_operation,
    input  logic [23:0] i_address,
    input  logic [7:0]  i_write_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_region,
    output logic [22:0] o_rom_index,
    output logic [7:0]  o_read_data,
    output logic        o_slow_access,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    import cbm_pkg::*;

    localparam int SW = $clog2(SAVE_RAM_BYTES);
    localparam logic [SW-1:0] CLR_LAST = SW'(SAVE_RAM_BYTES - 1);

    logic [1:0]    r_rom_layout;
    logic [3:0]    r_sram_size_code;
    logic          r_fast_rom_enable;
    logic          r_clearing;
    logic [SW-1:0] r_clr_addr;
    logic          r_s1_valid;
    logic          n_s1_valid;
    t_decode       r_s1_dec;
    logic          r_s1_read;
    logic          r_out_valid;
    logic          n_out_valid;
    t_region       r_out_region;
    logic [22:0]   r_out_rom_index;
    logic [7:0]    r_out_data;
    logic          r_out_slow;

    t_decode       dec;
    logic [SW-1:0] sram_index;
    logic          accept;
    logic          s1_advance;
    logic          ram_we;
    logic          ram_re;
    logic [SW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [7:0]    ram_rdata;
    logic          cfg_write;

    cbm_decode #(
        .SAVE_RAM_BYTES  (SAVE_RAM_BYTES),
        .ROM_SPACE_BYTES (ROM_SPACE_BYTES)
    ) u_decode (
        .i_rom_layout      (r_rom_layout),
        .i_sram_size_code  (r_sram_size_code),
        .i_fast_rom_enable (r_fast_rom_enable),
        .i_address         (i_address),
        .o_dec             (dec),
        .o_sram_index      (sram_index)
    );

    cbm_ram #(
        .WIDTH (8),
        .DEPTH (SAVE_RAM_BYTES)
    ) u_save_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (sram_index),
        .o_rdata (ram_rdata)
    );

    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;

    assign s1_advance = !r_out_valid || !i_stall;
    assign o_stall    = r_clearing || (r_s1_valid && !s1_advance);
    assign accept     = i_valid && !o_stall;

    always_comb begin
        ram_we    = r_clearing || (accept && dec.sram_en && i_operation);
        ram_re    = accept && dec.sram_en && !i_operation;
        ram_waddr = r_clearing ? r_clr_addr : sram_index;
        ram_wdata = r_clearing ? 8'd0 : i_write_data;
    end

    always_comb begin
        if (accept) begin
            n_s1_valid = 1'b1;
        end else if (s1_advance) begin
            n_s1_valid = 1'b0;
        end else begin
            n_s1_valid = r_s1_valid;
        end
        if (r_s1_valid && s1_advance) begin
            n_out_valid = 1'b1;
        end else if (i_stall) begin
            n_out_valid = r_out_valid;
        end else begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rom_layout      <= 2'd0;
            r_sram_size_code  <= 4'd0;
            r_fast_rom_enable <= 1'b0;
            r_clearing        <= 1'b1;
            r_clr_addr        <= '0;
            r_s1_valid        <= 1'b0;
            r_out_valid       <= 1'b0;
        end else begin
            if (cfg_write) begin
                case (i_cfg_index)
                    CFG_ROM_LAYOUT:      r_rom_layout      <= i_cfg_data[1:0];
                    CFG_SRAM_SIZE_CODE:  r_sram_size_code  <= i_cfg_data[3:0];
                    CFG_FAST_ROM_ENABLE: r_fast_rom_enable <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + SW'(1);
                if (r_clr_addr == CLR_LAST) begin
                    r_clearing <= 1'b0;
                end
            end
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_dec  <= dec;
            r_s1_read <= dec.sram_en && !i_operation;
        end
        if (r_s1_valid && s1_advance) begin
            r_out_region    <= r_s1_dec.region;
            r_out_rom_index <= r_s1_dec.rom_index;
            r_out_slow      <= r_s1_dec.slow;
            r_out_data      <= r_s1_read ? ram_rdata : 8'd0;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_region      = r_out_region;
    assign o_rom_index   = r_out_rom_index;
    assign o_read_data   = r_out_data;
    assign o_slow_access = r_out_slow;

    a_no_result_while_clearing: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !r_out_valid && !r_s1_valid
    ) else $error("result pending during save RAM clear");

    a_data_only_for_sram: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_region != REGION_SRAM)) |-> (r_out_data == 8'd0)
    ) else $error("read data outside save RAM region");

    a_fast_when_unmapped: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_region == REGION_NONE)) |-> !r_out_slow
    ) else $error("slow flag set on unmapped access");

    a_ram_port_exclusive: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re)
    ) else $error("save RAM read and write in one cycle");

endmodule
